// File: rtl/seqnum_direct_mapped_buffer_top_assert.svh
// Assertion macros for the sequence number buffer.
`ifndef SEQNUM_DIRECT_MAPPED_BUFFER_TOP_ASSERT_SVH
`define SEQNUM_DIRECT_MAPPED_BUFFER_TOP_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define SDMB_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdmb assertion failed");

// Property checked at every clock edge, reset included.
`define SDMB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sdmb assertion failed");

`endif

// File: rtl/sdmb_pkg.sv
package sdmb_pkg;

    localparam int KeyW        = 32;
    localparam int HandleW     = 16;
    localparam int ActionW     = 2;
    localparam int StatusW     = 3;
    localparam int OccW        = 11;
    localparam int DupW        = 32;
    localparam int BucketBits  = 10;
    localparam int HandleWidth = 16;
    localparam int QueueDepth  = 2;

    localparam logic [ActionW-1:0] ActInsert = 2'd0;
    localparam logic [ActionW-1:0] ActFind   = 2'd1;
    localparam logic [ActionW-1:0] ActDelete = 2'd2;

    localparam logic [StatusW-1:0] StInserted  = 3'd0;
    localparam logic [StatusW-1:0] StCollision = 3'd1;
    localparam logic [StatusW-1:0] StDuplicate = 3'd2;
    localparam logic [StatusW-1:0] StFound     = 3'd3;
    localparam logic [StatusW-1:0] StNotFound  = 3'd4;
    localparam logic [StatusW-1:0] StDeleted   = 3'd5;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_FIND,
        OP_DELETE,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic [ActionW-1:0] action;
        logic [KeyW-1:0]    seq_num;
        logic [HandleW-1:0] handle_in;
    } item_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [HandleW-1:0] handle_out;
        logic [OccW-1:0]    occupancy;
        logic [DupW-1:0]    dup_count;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [KeyW-1:0]    key;
        logic [HandleW-1:0] handle;
    } op_item_t;

endpackage

// File: rtl/seqnum_direct_mapped_buffer_top.sv
// Direct-mapped store of packet handles keyed by sequence number.
// The item channel (item_valid, item_ready, item) carries one table operation
// per transfer: insert, find or delete, with the sequence number as key.
// The result channel (result_valid, result_ready, result) returns exactly one
// result per operation, in order: a status, the handle found or deleted, the
// occupancy after the operation and the saturating duplicate count.
// An accepted operation goes into a two-entry queue; the execution side then
// pops it and reads its bucket from the table memory, then updates the bucket
// and registers the result in its execute state.
// The execution side finishes each operation before it takes the next, set by
// the read and then write turn on the single table memory port pair.
// After reset the table memory is swept once to mark all 2^INDEX_BITS buckets
// (1024 by default) empty; item_ready stays low until the sweep is done.
// When the receiver holds result_ready low, the result stays registered, the
// next operation waits, and the queue accepts up to two more items before
// item_ready drops.
module seqnum_direct_mapped_buffer_top
    import sdmb_pkg::*;
#(
    parameter int INDEX_BITS   = BucketBits,
    parameter int HANDLE_WIDTH = HandleWidth
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic     table_ready;
    logic     q_push;
    logic     q_ready;
    op_item_t q_push_item;
    logic     q_valid;
    logic     q_pop;
    op_item_t q_pop_item;

    sdmb_front u_front
    (
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .table_ready (table_ready),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    sdmb_queue #(
        .DEPTH (QueueDepth)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_pop_item)
    );

    sdmb_back #(
        .INDEX_BITS   (INDEX_BITS),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_pop_item),
        .q_pop        (q_pop),
        .table_ready  (table_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: rtl/sdmb_front.sv
module sdmb_front
    import sdmb_pkg::*;
(
    input  logic     item_valid,
    output logic     item_ready,
    input  item_t    item,
    input  logic     table_ready,
    input  logic     q_ready,
    output logic     q_push,
    output op_item_t q_item
);

    op_t op;

    always_comb
    begin
        unique case (item.action)
            ActInsert: op = OP_INSERT;
            ActFind:   op = OP_FIND;
            ActDelete: op = OP_DELETE;
            default:   op = OP_NONE;
        endcase
    end

    assign item_ready = q_ready && table_ready;
    assign q_push     = item_valid && item_ready;
    assign q_item     = '{op: op, key: item.seq_num, handle: item.handle_in};

endmodule

// File: rtl/sdmb_queue.sv
module sdmb_queue
    import sdmb_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  op_item_t push_item,
    output logic     push_ready,
    output logic     pop_valid,
    input  logic     pop,
    output op_item_t pop_item
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    op_item_t        slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/sdmb_back.sv
module sdmb_back
    import sdmb_pkg::*;
#(
    parameter int INDEX_BITS   = BucketBits,
    parameter int HANDLE_WIDTH = HandleWidth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  op_item_t q_item,
    output logic     q_pop,
    output logic     table_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    localparam int Depth  = 1 << INDEX_BITS;
    localparam int EntryW = 1 + KeyW + HANDLE_WIDTH;
    localparam int CntW   = INDEX_BITS + 1;
    localparam int PadW   = HANDLE_WIDTH + HandleW;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [INDEX_BITS-1:0]   clr_addr_reg;
    logic [INDEX_BITS-1:0]   clr_addr_next;
    op_item_t                cur_reg;
    op_item_t                cur_next;
    logic [CntW-1:0]         occ_reg;
    logic [CntW-1:0]         occ_next;
    logic [DupW-1:0]         dups_reg;
    logic [DupW-1:0]         dups_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    result_t                 res_reg;
    result_t                 res_next;

    logic [EntryW-1:0]       mem [Depth];
    logic [EntryW-1:0]       rd_data_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [INDEX_BITS-1:0]   mem_raddr;
    logic [EntryW-1:0]       mem_wdata;

    logic                    rd_valid;
    logic [KeyW-1:0]         rd_key;
    logic [HANDLE_WIDTH-1:0] rd_handle;
    logic                    hit;
    logic                    slot_free;
    logic [PadW-1:0]         hin_wide;
    logic [PadW-1:0]         hout_wide;
    logic [HANDLE_WIDTH-1:0] hin_stored;
    logic [HandleW-1:0]      hout_port;
    logic [CntW+OccW-1:0]    occ_wide;

    assign rd_valid   = rd_data_reg[EntryW-1];
    assign rd_key     = rd_data_reg[HANDLE_WIDTH +: KeyW];
    assign rd_handle  = rd_data_reg[HANDLE_WIDTH-1:0];
    assign hit        = rd_valid && (rd_key == cur_reg.key);
    assign slot_free  = !res_valid_reg || result_ready;
    assign hin_wide   = PadW'(cur_reg.handle);
    assign hin_stored = hin_wide[HANDLE_WIDTH-1:0];
    assign hout_wide  = PadW'(rd_handle);
    assign hout_port  = hout_wide[HandleW-1:0];

    assign table_ready  = (state_reg != BK_CLEAR);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_next       = cur_reg;
        occ_next       = occ_reg;
        dups_next      = dups_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cur_reg.key[INDEX_BITS-1:0];
        mem_raddr      = q_item.key[INDEX_BITS-1:0];
        mem_wdata      = '0;
        q_pop          = 1'b0;
        occ_wide       = '0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    cur_next   = q_item;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (slot_free)
                begin
                    res_next.handle_out = '0;
                    res_next.status     = StNotFound;
                    unique case (cur_reg.op)
                        OP_INSERT:
                        begin
                            if (!rd_valid)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = {1'b1, cur_reg.key, hin_stored};
                                occ_next        = occ_reg + 1'b1;
                                res_next.status = StInserted;
                            end
                            else if (!hit)
                            begin
                                res_next.status = StCollision;
                            end
                            else
                            begin
                                if (dups_reg != '1)
                                begin
                                    dups_next = dups_reg + 1'b1;
                                end
                                res_next.status = StDuplicate;
                            end
                        end
                        OP_FIND:
                        begin
                            if (hit)
                            begin
                                res_next.handle_out = hout_port;
                                res_next.status     = StFound;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (hit)
                            begin
                                mem_we              = 1'b1;
                                mem_wdata           = {1'b0, rd_key, rd_handle};
                                res_next.handle_out = hout_port;
                                res_next.status     = StDeleted;
                                if (occ_reg != '0)
                                begin
                                    occ_next = occ_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.status = StNotFound;
                        end
                    endcase
                    occ_wide           = (CntW + OccW)'(occ_next);
                    res_next.occupancy = occ_wide[OccW-1:0];
                    res_next.dup_count = dups_next;
                    res_valid_next     = 1'b1;
                    state_next         = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            occ_reg       <= '0;
            dups_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            occ_reg       <= occ_next;
            dups_reg      <= dups_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// File: rtl/sdmb_checker.sv
`include "seqnum_direct_mapped_buffer_top_assert.svh"

module sdmb_checker
    import sdmb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    `SDMB_ASSERT_CLK(a_result_hold, clk, rst_n,
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))

    `SDMB_ASSERT_CLK(a_handle_zero, clk, rst_n,
        (result_valid && result.status != StFound && result.status != StDeleted)
            |-> (result.handle_out == '0))

    `SDMB_ASSERT_CLK(a_insert_occupied, clk, rst_n,
        (result_valid && result.status == StInserted) |-> (result.occupancy != '0))

    `SDMB_ASSERT_ALWAYS(a_reset_not_ready, clk, !rst_n |=> !item_ready)

endmodule

bind seqnum_direct_mapped_buffer_top sdmb_checker u_sdmb_checker (.*);

// File: tb/tb_top.sv
module tb_top;
    import sdmb_pkg::*;

    localparam int NumBuckets = 1 << BucketBits;
    localparam logic [ActionW-1:0] ActSpare = 2'd3;
    localparam logic [HandleW-1:0] HandleMask = HandleW'((64'd1 << HandleWidth) - 64'd1);
    localparam int RandomOps = 1280;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 20;
    localparam int HoldAfter = 300;
    localparam int HoldCycles = 400;
    localparam int RecentKeys = 64;

    typedef struct {
        item_t   op;
        bit      fixed;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    logic                bk_valid [NumBuckets];
    logic [KeyW-1:0]     bk_key [NumBuckets];
    logic [HandleW-1:0]  bk_handle [NumBuckets];
    logic [OccW-1:0]     held;
    logic [DupW-1:0]     dups;

    result_t         pending_q [$];
    stim_row_t       rows [$];
    logic [KeyW-1:0] recent_keys [$];

    bit      row_fixed;
    result_t row_want;
    int      err_count;
    int      results_seen;
    int      cycles;
    bit      tx_steady;
    bit      rx_steady;

    seqnum_direct_mapped_buffer_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t apply_op(input item_t op);
        logic [BucketBits-1:0] b;
        logic                  hit;
        result_t               r;
        b = op.seq_num[BucketBits-1:0];
        hit = bk_valid[b] && (bk_key[b] == op.seq_num);
        r = '0;
        case (op.action)
            ActInsert:
            begin
                if (!bk_valid[b])
                begin
                    bk_valid[b] = 1'b1;
                    bk_key[b] = op.seq_num;
                    bk_handle[b] = op.handle_in & HandleMask;
                    held = held + 1'b1;
                    r.status = StInserted;
                end
                else if (!hit)
                begin
                    r.status = StCollision;
                end
                else
                begin
                    if (dups != '1)
                    begin
                        dups = dups + 1'b1;
                    end
                    r.status = StDuplicate;
                end
            end
            ActFind:
            begin
                if (hit)
                begin
                    r.handle_out = bk_handle[b];
                    r.status = StFound;
                end
                else
                begin
                    r.status = StNotFound;
                end
            end
            ActDelete:
            begin
                if (hit)
                begin
                    r.handle_out = bk_handle[b];
                    bk_valid[b] = 1'b0;
                    if (held != '0)
                    begin
                        held = held - 1'b1;
                    end
                    r.status = StDeleted;
                end
                else
                begin
                    r.status = StNotFound;
                end
            end
            default:
            begin
                r.status = StNotFound;
            end
        endcase
        r.occupancy = held;
        r.dup_count = dups;
        return r;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_q.size() == 0)
        begin
            if (err_count < 10)
            begin
                $display("Result transfer with nothing outstanding: status %0d handle %h",
                         got.status, got.handle_out);
            end
            err_count++;
        end
        else
        begin
            want = pending_q.pop_front();
            if (got.status !== want.status || got.handle_out !== want.handle_out ||
                got.occupancy !== want.occupancy || got.dup_count !== want.dup_count)
            begin
                if (err_count < 10)
                begin
                    $display("Mismatch: expected status %0d handle %h occupancy %0d dups %0d",
                             want.status, want.handle_out, want.occupancy, want.dup_count);
                    $display("          got      status %0d handle %h occupancy %0d dups %0d",
                             got.status, got.handle_out, got.occupancy, got.dup_count);
                end
                err_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        cycles = cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                check_result(result);
            end
            if (item_valid && item_ready)
            begin
                exp_r = apply_op(item);
                if (row_fixed)
                begin
                    exp_r = row_want;
                end
                pending_q.push_back(exp_r);
            end
        end
    end

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_op(input int idx);
        item_t op;
        int    r;
        int    insert_pct;
        r = $urandom_range(0, 99);
        insert_pct = ((idx / 200) % 2 == 0) ? 60 : 30;
        if (r < insert_pct)
        begin
            op.action = ActInsert;
        end
        else if (r < insert_pct + 20)
        begin
            op.action = ActFind;
        end
        else if (r < 97)
        begin
            op.action = ActDelete;
        end
        else
        begin
            op.action = ActSpare;
        end
        r = $urandom_range(0, 99);
        if (r < 45 && recent_keys.size() > 0)
        begin
            op.seq_num = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end
        else if (r < 80)
        begin
            op.seq_num = $urandom;
            op.seq_num[BucketBits-1:0] = BucketBits'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0: op.seq_num[KeyW-1:BucketBits] = '0;
                1: op.seq_num[KeyW-1:BucketBits] = '1;
                2: op.seq_num[KeyW-1:BucketBits] = (KeyW - BucketBits)'(1);
                default: ;
            endcase
        end
        else
        begin
            op.seq_num = $urandom;
        end
        op.handle_in = HandleW'($urandom);
        if (op.action == ActInsert)
        begin
            recent_keys.push_back(op.seq_num);
            if (recent_keys.size() > RecentKeys)
            begin
                void'(recent_keys.pop_front());
            end
        end
        return op;
    endfunction

    task automatic add_row(input logic [ActionW-1:0] act, input logic [KeyW-1:0] seq,
                           input logic [HandleW-1:0] h, input bit fixed,
                           input logic [StatusW-1:0] st, input logic [HandleW-1:0] hout,
                           input int occ, input int dup);
        stim_row_t row;
        row.op.action = act;
        row.op.seq_num = seq;
        row.op.handle_in = h;
        row.fixed = fixed;
        row.want.status = st;
        row.want.handle_out = hout;
        row.want.occupancy = OccW'(occ);
        row.want.dup_count = DupW'(dup);
        rows.push_back(row);
    endtask

    task automatic send_op(input item_t op, input bit fixed, input result_t want);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= op;
        row_fixed <= fixed;
        row_want <= want;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    initial
    begin
        int  stall;
        bit  hold_done;
        result_ready = 1'b0;
        stall = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HoldAfter)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                begin
                    rx_steady = !rx_steady;
                end
                if (!rx_steady && $urandom_range(0, 4) == 0)
                begin
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        row_fixed = 1'b0;
        row_want = '0;
        err_count = 0;
        results_seen = 0;
        cycles = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        held = '0;
        dups = '0;
        foreach (bk_valid[i])
        begin
            bk_valid[i] = 1'b0;
            bk_key[i] = '0;
            bk_handle[i] = '0;
        end

        add_row(ActFind,   32'h0000_0000, 16'h0000, 1, StNotFound,  16'h0000, 0, 0);
        add_row(ActDelete, 32'hFFFF_FFFF, 16'hFFFF, 1, StNotFound,  16'h0000, 0, 0);
        add_row(ActInsert, 32'h0000_0000, 16'h0000, 1, StInserted,  16'h0000, 1, 0);
        add_row(ActInsert, 32'hFFFF_FFFF, 16'hFFFF, 1, StInserted,  16'h0000, 2, 0);
        add_row(ActInsert, 32'h0000_0400, 16'h1234, 1, StCollision, 16'h0000, 2, 0);
        add_row(ActInsert, 32'h0000_0000, 16'h5555, 1, StDuplicate, 16'h0000, 2, 1);
        add_row(ActFind,   32'h0000_0000, 16'hAAAA, 1, StFound,     16'h0000, 2, 1);
        add_row(ActFind,   32'hFFFF_FFFF, 16'h0000, 1, StFound,     16'hFFFF, 2, 1);
        add_row(ActFind,   32'h0000_0400, 16'h0000, 1, StNotFound,  16'h0000, 2, 1);
        add_row(ActSpare,  32'h0000_0000, 16'hABCD, 1, StNotFound,  16'h0000, 2, 1);
        add_row(ActDelete, 32'h0000_0400, 16'h0000, 1, StNotFound,  16'h0000, 2, 1);
        add_row(ActDelete, 32'h0000_0000, 16'h0000, 1, StDeleted,   16'h0000, 1, 1);
        add_row(ActFind,   32'h0000_0000, 16'h0000, 1, StNotFound,  16'h0000, 1, 1);
        add_row(ActInsert, 32'h0000_0400, 16'h1234, 1, StInserted,  16'h0000, 2, 1);
        add_row(ActInsert, 32'h0000_0400, 16'h0000, 1, StDuplicate, 16'h0000, 2, 2);
        add_row(ActDelete, 32'hFFFF_FFFF, 16'h0000, 1, StDeleted,   16'hFFFF, 1, 2);
        add_row(ActInsert, 32'h8000_0155, 16'h8000, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActInsert, 32'h7FFF_FEAA, 16'h7FFF, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActInsert, 32'hFFFF_FD55, 16'h0F0F, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActFind,   32'h8000_0155, 16'h0000, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActDelete, 32'h7FFF_FEAA, 16'h0000, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActFind,   32'h7FFF_FEAA, 16'h0000, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActDelete, 32'h0000_0400, 16'h0000, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActSpare,  32'hFFFF_FFFF, 16'hFFFF, 0, StInserted,  16'h0000, 0, 0);
        add_row(ActFind,   32'hAAAA_AAAA, 16'h5555, 0, StInserted,  16'h0000, 0, 0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_op(rows[i].op, rows[i].fixed, rows[i].want);
        end
        for (int i = 0; i < RandomOps; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
            end
            send_op(make_op(i), 1'b0, '0);
        end
        item_valid <= 1'b0;

        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sdmb_pkg.sv
rtl/sdmb_front.sv
rtl/sdmb_queue.sv
rtl/sdmb_back.sv
rtl/seqnum_direct_mapped_buffer_top.sv
rtl/sdmb_checker.sv
tb/tb_top.sv
